// ===== rtl/core/stb_pkg.sv =====
// Shared types and codes for the software timer bank.
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

    localparam int TIME_W = 32;

    localparam logic [1:0] OP_SCAN   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_RANGE  = 2'd1;
    localparam logic [1:0] STS_MODE   = 2'd2;
    localparam logic [1:0] STS_NOFREE = 2'd3;

    typedef struct packed {
        logic              sub;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } alu_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/stb_alu.sv =====
// Shared 32-bit adder that also serves as the match-time comparator.
`timescale 1ns / 1ps
`default_nettype none

module stb_alu
    import stb_pkg::*;
(
    input  alu_req_t          req,
    output logic [TIME_W-1:0] sum,
    output logic              le
);

    logic [TIME_W-1:0] opa;
    logic [TIME_W:0]   full;

    // Subtraction forms b - a; a carry out means a is not greater than b.
    assign opa  = req.sub ? ~req.a : req.a;
    assign full = {1'b0, opa} + {1'b0, req.b} + (TIME_W + 1)'(req.sub);
    assign sum  = full[TIME_W-1:0];
    assign le   = full[TIME_W];

endmodule

`default_nettype wire

// ===== rtl/core/stb_ram.sv =====
// Single-port-write, registered-read memory for per-timer time values.
`timescale 1ns / 1ps
`default_nettype none

module stb_ram
    import stb_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [TIME_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic [TIME_W-1:0]      rdata
);

    logic [TIME_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/soft_timer_bank.sv =====
// Software timer bank top level: command sequencer, timer flags and time stores.
//
// The request channel (req_valid, req_stall) carries one command per transfer:
// a scan step, a timer create, a timer delete or a state query, each with the
// current tick count. The response channel (rsp_valid, rsp_stall) returns
// exactly one result per command, in order.
// The block works on one command at a time and holds req_stall high until the
// result has been placed in the response register. A delete, a query, a rejected
// create and a scan step at the idle pointer value go straight to S_DONE; other
// scan steps pass through S_EXEC and a valid explicit create through S_ARM. A
// create with id 0 walks the allocated flags one timer per cycle in S_SEARCH,
// then goes to S_ARM, or to S_DONE with STS_NOFREE. The next request is taken
// in the cycle after the response register loads. The time arithmetic and
// compare all go through one shared 32-bit adder, and match times and periods
// sit in memories with a registered read port. Reset stops and frees every
// timer and returns the scan pointer to zero; no clearing pass is needed.
// While the receiver stalls, the response is held and the finished command
// waits in the sequencer, with req_stall high, until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module soft_timer_bank
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic [1:0]        operation,
    input  wire logic [7:0]        timer_id,
    input  wire logic [1:0]        timer_mode,
    input  wire logic [TIME_W-1:0] delay,
    input  wire logic [TIME_W-1:0] now,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic                   fired,
    output logic [3:0]             fired_id,
    output logic [3:0]             assigned_id,
    output logic [1:0]             status,
    output logic [1:0]             state_read
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int PTR_W = $clog2(NUM_TIMERS + 1);
    localparam logic [8:0] NUM_ID = 9'(NUM_TIMERS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_ARM    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        fsm_reg, fsm_next;
    logic [PTR_W-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [IDX_W-1:0]  target_reg, target_next;
    logic [IDX_W-1:0]  search_reg, search_next;
    logic              mode_reg, mode_next;
    logic [TIME_W-1:0] delay_reg, delay_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              res_fired_reg, res_fired_next;
    logic [3:0]        res_fired_id_reg, res_fired_id_next;
    logic [3:0]        res_assigned_reg, res_assigned_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [1:0]        res_sread_reg, res_sread_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              fired_reg;
    logic [3:0]        fired_id_reg;
    logic [3:0]        assigned_reg;
    logic [1:0]        status_reg;
    logic [1:0]        sread_reg;

    logic [1:0]        tstate_reg [NUM_TIMERS];
    logic              periodic_reg [NUM_TIMERS];
    logic              alloc_reg [NUM_TIMERS];

    logic              ent_we;
    logic [IDX_W-1:0]  ent_idx;
    logic [1:0]        ent_state;
    logic              alloc_we;
    logic              alloc_val;
    logic              per_we;
    logic              match_we;
    logic              period_we;
    logic              load_rsp;
    logic              id_out;
    logic [IDX_W-1:0]  id_idx;
    logic [IDX_W-1:0]  ram_raddr;
    logic [1:0]        cur_state;
    logic [TIME_W-1:0] match_rd;
    logic [TIME_W-1:0] period_rd;
    logic [TIME_W-1:0] alu_sum;
    logic              alu_le;
    alu_req_t          alu_req;

    assign id_out    = {1'b0, timer_id} >= NUM_ID;
    assign id_idx    = timer_id[IDX_W-1:0];
    assign ram_raddr = (fsm_reg == S_IDLE) ? scan_ptr_reg[IDX_W-1:0] : target_reg;
    assign cur_state = tstate_reg[target_reg];

    stb_alu u_alu
    (
        .req (alu_req),
        .sum (alu_sum),
        .le  (alu_le)
    );

    stb_ram #(.DEPTH(NUM_TIMERS), .AW(IDX_W)) u_match_ram
    (
        .clk   (clk),
        .we    (match_we),
        .waddr (target_reg),
        .wdata (alu_sum),
        .raddr (ram_raddr),
        .rdata (match_rd)
    );

    stb_ram #(.DEPTH(NUM_TIMERS), .AW(IDX_W)) u_period_ram
    (
        .clk   (clk),
        .we    (period_we),
        .waddr (target_reg),
        .wdata (delay_reg),
        .raddr (ram_raddr),
        .rdata (period_rd)
    );

    always_comb
    begin
        fsm_next          = fsm_reg;
        scan_ptr_next     = scan_ptr_reg;
        target_next       = target_reg;
        search_next       = search_reg;
        mode_next         = mode_reg;
        delay_next        = delay_reg;
        now_next          = now_reg;
        res_fired_next    = res_fired_reg;
        res_fired_id_next = res_fired_id_reg;
        res_assigned_next = res_assigned_reg;
        res_status_next   = res_status_reg;
        res_sread_next    = res_sread_reg;
        ent_we            = 1'b0;
        ent_idx           = target_reg;
        ent_state         = ST_STOPPED;
        alloc_we          = 1'b0;
        alloc_val         = 1'b0;
        per_we            = 1'b0;
        match_we          = 1'b0;
        period_we         = 1'b0;
        load_rsp          = 1'b0;
        alu_req.sub       = 1'b0;
        alu_req.a         = delay_reg;
        alu_req.b         = now_reg;

        unique case (fsm_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    now_next          = now;
                    delay_next        = delay;
                    mode_next         = timer_mode[0];
                    res_fired_next    = 1'b0;
                    res_fired_id_next = 4'd0;
                    res_assigned_next = 4'd0;
                    res_status_next   = STS_OK;
                    res_sread_next    = ST_STOPPED;
                    fsm_next          = S_DONE;
                    unique case (operation)
                        OP_SCAN:
                        begin
                            if (scan_ptr_reg == PTR_W'(NUM_TIMERS))
                            begin
                                scan_ptr_next = '0;
                            end
                            else
                            begin
                                target_next = scan_ptr_reg[IDX_W-1:0];
                                fsm_next    = S_EXEC;
                            end
                        end
                        OP_CREATE:
                        begin
                            if (id_out)
                            begin
                                res_status_next = STS_RANGE;
                            end
                            else if (timer_mode > 2'd1)
                            begin
                                res_status_next = STS_MODE;
                            end
                            else if (timer_id == 8'd0)
                            begin
                                search_next = '0;
                                fsm_next    = S_SEARCH;
                            end
                            else
                            begin
                                target_next = id_idx;
                                fsm_next    = S_ARM;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (id_out)
                            begin
                                res_status_next = STS_RANGE;
                            end
                            else
                            begin
                                ent_we    = 1'b1;
                                ent_idx   = id_idx;
                                ent_state = ST_STOPPED;
                                alloc_we  = 1'b1;
                                alloc_val = 1'b0;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (id_out)
                            begin
                                res_status_next = STS_RANGE;
                            end
                            else
                            begin
                                res_sread_next = tstate_reg[id_idx];
                            end
                        end
                        default:
                        begin
                            res_status_next = STS_OK;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                scan_ptr_next = scan_ptr_reg + 1'b1;
                fsm_next      = S_DONE;
                if (cur_state == ST_RUNNING)
                begin
                    alu_req.sub = 1'b1;
                    alu_req.a   = match_rd;
                    if (alu_le)
                    begin
                        ent_we            = 1'b1;
                        ent_state         = ST_TIMEOUT;
                        res_fired_next    = 1'b1;
                        res_fired_id_next = 4'(target_reg);
                    end
                end
                else if (cur_state == ST_TIMEOUT)
                begin
                    ent_we = 1'b1;
                    if (periodic_reg[target_reg])
                    begin
                        alu_req.a = period_rd;
                        match_we  = 1'b1;
                        ent_state = ST_RUNNING;
                    end
                    else
                    begin
                        ent_state = ST_STOPPED;
                    end
                end
            end
            S_SEARCH:
            begin
                if (!alloc_reg[search_reg])
                begin
                    target_next = search_reg;
                    fsm_next    = S_ARM;
                end
                else if (search_reg == IDX_W'(NUM_TIMERS - 1))
                begin
                    res_status_next = STS_NOFREE;
                    fsm_next        = S_DONE;
                end
                else
                begin
                    search_next = search_reg + 1'b1;
                end
            end
            S_ARM:
            begin
                match_we          = 1'b1;
                period_we         = 1'b1;
                ent_we            = 1'b1;
                ent_state         = ST_RUNNING;
                alloc_we          = 1'b1;
                alloc_val         = 1'b1;
                per_we            = 1'b1;
                res_assigned_next = 4'(target_reg);
                fsm_next          = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_rsp = 1'b1;
                    fsm_next = S_IDLE;
                end
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase

        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            scan_ptr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                tstate_reg[i]   <= ST_STOPPED;
                periodic_reg[i] <= 1'b0;
                alloc_reg[i]    <= 1'b0;
            end
        end
        else
        begin
            fsm_reg       <= fsm_next;
            scan_ptr_reg  <= scan_ptr_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ent_we)
            begin
                tstate_reg[ent_idx] <= ent_state;
            end
            if (alloc_we)
            begin
                alloc_reg[ent_idx] <= alloc_val;
            end
            if (per_we)
            begin
                periodic_reg[ent_idx] <= mode_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg       <= target_next;
        search_reg       <= search_next;
        mode_reg         <= mode_next;
        delay_reg        <= delay_next;
        now_reg          <= now_next;
        res_fired_reg    <= res_fired_next;
        res_fired_id_reg <= res_fired_id_next;
        res_assigned_reg <= res_assigned_next;
        res_status_reg   <= res_status_next;
        res_sread_reg    <= res_sread_next;
        if (load_rsp)
        begin
            fired_reg    <= res_fired_reg;
            fired_id_reg <= res_fired_id_reg;
            assigned_reg <= res_assigned_reg;
            status_reg   <= res_status_reg;
            sread_reg    <= res_sread_reg;
        end
    end

    assign req_stall   = (fsm_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign fired       = fired_reg;
    assign fired_id    = fired_id_reg;
    assign assigned_id = assigned_reg;
    assign status      = status_reg;
    assign state_read  = sread_reg;

    logic [NUM_TIMERS-1:0] orphan;

    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            orphan[i] = (tstate_reg[i] != ST_STOPPED) && !alloc_reg[i];
        end
    end

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_ptr_reg <= PTR_W'(NUM_TIMERS))
        else $error("scan pointer beyond idle step");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        orphan == '0)
        else $error("active timer is not allocated");

    a_fire_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && fired) |->
            (status == STS_OK && assigned_id == 4'd0 && state_read == ST_STOPPED))
        else $error("fired result carries other fields");

    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_DONE && (!rsp_valid_reg || !rsp_stall)) |=>
            (rsp_valid_reg && fsm_reg == S_IDLE))
        else $error("finished command produced no response");

endmodule

`default_nettype wire
